// ===== rtl/core/pmc_pkg.sv =====
// Shared types and constants of the pitch PD magnetorquer controller.
package pmc_pkg;

  localparam int MAG_W = 18;
  localparam int ANGLE_W = 25;
  localparam int RATE_W = 22;
  localparam int MOMENT_W = 15;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam int SAT_LIMIT = 13107;
  localparam logic [29:0] NT_SCALE = 30'd1000000000;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_P_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_D_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUTATION_GAIN = 2'd2;

  localparam logic [4:0] MUL_LAST = 5'd16;
  localparam int QUO_BITS = 14;
  localparam logic [3:0] DIV_LAST = 4'(QUO_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_ITER,
    ST_FINISH
  } pmc_state_t;

endpackage

// ===== rtl/core/pmc_if.sv =====
// Valid/ready channel interfaces for the sample input and the moment result.
interface pmc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pmc_pkg::MAG_W-1:0]    mag_x;
  logic signed [pmc_pkg::MAG_W-1:0]    mag_y;
  logic signed [pmc_pkg::MAG_W-1:0]    mag_z;
  logic signed [pmc_pkg::ANGLE_W-1:0]  pitch_angle;
  logic signed [pmc_pkg::RATE_W-1:0]   pitch_rate;
  logic signed [pmc_pkg::MAG_W-1:0]    ref_y_change;

  modport source (output valid, mag_x, mag_y, mag_z, pitch_angle, pitch_rate, ref_y_change,
                  input ready);
  modport sink (input valid, mag_x, mag_y, mag_z, pitch_angle, pitch_rate, ref_y_change,
                output ready);
endinterface

interface pmc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pmc_pkg::MOMENT_W-1:0] moment_x;
  logic signed [pmc_pkg::MOMENT_W-1:0] moment_y;
  logic signed [pmc_pkg::MOMENT_W-1:0] moment_z;
  logic                                field_zero;

  modport source (output valid, moment_x, moment_y, moment_z, field_zero, input ready);
  modport sink (input valid, moment_x, moment_y, moment_z, field_zero, output ready);
endinterface

// ===== rtl/core/pitch_pd_magnetorquer_control.sv =====
// Top level of the pitch PD magnetorquer controller with nutation damping.
//
//   channel  | direction | handshake          | payload
//   in_ch    | in        | valid/ready        | mag_x/y/z, pitch_angle, pitch_rate, ref_y_change
//   out_ch   | out       | valid/ready        | moment_x/y/z, field_zero
//   cfg_*    | in        | write enable only  | cfg_index, cfg_wdata
//
// Each item runs through the shared 33x33 multiplier, then per moment axis takes the
// saturated quotient or the restoring divider, and last loads the output register.
// Synchronous active-low reset clears the gains, the stored Y field and the first flag.
// The input is not ready while an item is at work; a result that is not taken holds
// the finished item in place until the output register frees up.
module pitch_pd_magnetorquer_control (
  input  logic                                  clk,
  input  logic                                  rst_n,
  pmc_in_if.sink                                in_ch,
  pmc_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic [pmc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pmc_pkg::CFG_W-1:0]             cfg_wdata
);

  pmc_pkg::pmc_state_t state_r, state_nxt;

  logic signed [31:0] p_gain_r, d_gain_r, n_gain_r;
  logic signed [17:0] prev_y_r;
  logic               seen_r;

  logic signed [17:0] bx_r, by_r, bz_r;
  logic signed [24:0] th_r;
  logic signed [21:0] rt_r;
  logic signed [19:0] e_r;
  logic               zero_r;

  logic [4:0]          step_r;
  logic signed [65:0]  prod_r;
  logic signed [56:0]  acc_r;
  logic [57:0]         tq_abs_r;
  logic                tq_neg_r;
  logic [47:0]         ax_r, az_r;
  logic [35:0]         b2_r;
  logic [103:0]        nx_r, nz_r;
  logic signed [14:0]  mx_r, my_r, mz_r;

  logic                div_z_r;
  logic [3:0]          cnt_r;
  logic [51:0]         rem_r;
  logic [13:0]         low_r;
  logic [12:0]         q_r;

  logic                out_valid_r;
  logic signed [14:0]  out_mx_r, out_my_r, out_mz_r;
  logic                out_zero_r;

  logic                in_ready, in_fire, out_load;

  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mul_p;
  logic [17:0]         abs_bx, abs_bz;
  logic [47:0]         a_sel;
  logic [23:0]         a_part;
  logic [28:0]         t_part;
  logic [1:0]          op_idx;
  logic [103:0]        part_sh;

  logic [51:0]         den;
  logic [103:0]        n_sel;
  logic                div_sat, div_ge, div_neg;
  logic [52:0]         trial;
  logic [13:0]         q_fin;
  logic [14:0]         mag_lim;
  logic signed [14:0]  div_res;

  logic signed [18:0]  dby;
  logic signed [14:0]  my_sat;

  // The sequencer steps through the multiply, divide and output phases.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmc_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = pmc_pkg::ST_MUL;
      end
      pmc_pkg::ST_MUL: begin
        if (step_r == pmc_pkg::MUL_LAST) state_nxt = pmc_pkg::ST_DIV_START;
      end
      pmc_pkg::ST_DIV_START: begin
        if (div_sat) begin
          state_nxt = div_z_r ? pmc_pkg::ST_FINISH : pmc_pkg::ST_DIV_START;
        end else begin
          state_nxt = pmc_pkg::ST_DIV_ITER;
        end
      end
      pmc_pkg::ST_DIV_ITER: begin
        if (cnt_r == pmc_pkg::DIV_LAST) begin
          state_nxt = div_z_r ? pmc_pkg::ST_FINISH : pmc_pkg::ST_DIV_START;
        end
      end
      pmc_pkg::ST_FINISH: begin
        if (out_load) state_nxt = pmc_pkg::ST_IDLE;
      end
      default: state_nxt = pmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      pmc_pkg::ST_IDLE:   in_ready = 1'b1;
      pmc_pkg::ST_FINISH: out_load = !out_valid_r || out_ch.ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_fire = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // The step counter selects the operands of the shared multiplier.
  assign abs_bx = bx_r[17] ? 18'(-bx_r) : 18'(bx_r);
  assign abs_bz = bz_r[17] ? 18'(-bz_r) : 18'(bz_r);
  assign a_sel  = step_r[2] ? ax_r : az_r;
  assign a_part = step_r[1] ? a_sel[47:24] : a_sel[23:0];
  assign t_part = step_r[0] ? tq_abs_r[57:29] : tq_abs_r[28:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      5'd0: begin mul_a = 33'(p_gain_r); mul_b = 33'(th_r); end
      5'd1: begin mul_a = 33'(d_gain_r); mul_b = 33'(rt_r); end
      5'd2: begin mul_a = {15'b0, abs_bz}; mul_b = {3'b0, pmc_pkg::NT_SCALE}; end
      5'd3: begin mul_a = {15'b0, abs_bx}; mul_b = {3'b0, pmc_pkg::NT_SCALE}; end
      5'd4: begin mul_a = 33'(bx_r); mul_b = 33'(bx_r); end
      5'd5: begin mul_a = 33'(by_r); mul_b = 33'(by_r); end
      5'd6: begin mul_a = 33'(bz_r); mul_b = 33'(bz_r); end
      5'd7: begin mul_a = 33'(n_gain_r); mul_b = 33'(e_r); end
      5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: begin
        mul_a = {9'b0, a_part};
        mul_b = {4'b0, t_part};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Partial products of the cross-term numerators are aligned to their weight.
  assign op_idx = step_r[1:0] - 2'd1;
  always_comb begin
    case (op_idx)
      2'd0:    part_sh = {51'b0, prod_r[52:0]};
      2'd1:    part_sh = {51'b0, prod_r[52:0]} << 29;
      2'd2:    part_sh = {51'b0, prod_r[52:0]} << 24;
      default: part_sh = {51'b0, prod_r[52:0]} << 53;
    endcase
  end

  always_comb begin
    if (prod_r > pmc_pkg::SAT_LIMIT) begin
      my_sat = 15'(pmc_pkg::SAT_LIMIT);
    end else if (prod_r < -pmc_pkg::SAT_LIMIT) begin
      my_sat = 15'(-pmc_pkg::SAT_LIMIT);
    end else begin
      my_sat = prod_r[14:0];
    end
  end

  // One restoring divider is shared by the X and Z moments.
  assign den     = {b2_r, 16'b0};
  assign n_sel   = div_z_r ? nz_r : nx_r;
  assign div_sat = n_sel[103:14] >= {38'b0, den};
  assign div_neg = div_z_r ? ((bx_r[17]) != tq_neg_r)
                           : ((!bz_r[17] && (bz_r != '0)) != tq_neg_r);
  assign trial   = {rem_r, low_r[13]};
  assign div_ge  = trial >= {1'b0, den};
  assign q_fin   = {q_r, div_ge};

  always_comb begin
    if (state_r == pmc_pkg::ST_DIV_START) begin
      mag_lim = 15'(pmc_pkg::SAT_LIMIT);
    end else if ({1'b0, q_fin} > 15'(pmc_pkg::SAT_LIMIT)) begin
      mag_lim = 15'(pmc_pkg::SAT_LIMIT);
    end else begin
      mag_lim = {1'b0, q_fin};
    end
    div_res = div_neg ? -$signed(mag_lim) : $signed(mag_lim);
  end

  assign dby = seen_r ? (19'(in_ch.mag_y) - 19'(prev_y_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmc_pkg::ST_IDLE;
      p_gain_r    <= '0;
      d_gain_r    <= '0;
      n_gain_r    <= '0;
      prev_y_r    <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      cnt_r       <= '0;
      div_z_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          pmc_pkg::REG_PITCH_P_GAIN:  p_gain_r <= $signed(cfg_wdata);
          pmc_pkg::REG_PITCH_D_GAIN:  d_gain_r <= $signed(cfg_wdata);
          pmc_pkg::REG_NUTATION_GAIN: n_gain_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end

      if (in_fire) begin
        prev_y_r <= in_ch.mag_y;
        seen_r   <= 1'b1;
        step_r   <= '0;
        div_z_r  <= 1'b0;
      end

      if (state_r == pmc_pkg::ST_MUL) begin
        step_r <= step_r + 5'd1;
      end

      if (state_r == pmc_pkg::ST_DIV_START) begin
        cnt_r <= '0;
        if (div_sat) div_z_r <= 1'b1;
      end

      if (state_r == pmc_pkg::ST_DIV_ITER) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == pmc_pkg::DIV_LAST) div_z_r <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bx_r   <= in_ch.mag_x;
      by_r   <= in_ch.mag_y;
      bz_r   <= in_ch.mag_z;
      th_r   <= in_ch.pitch_angle;
      rt_r   <= in_ch.pitch_rate;
      e_r    <= 20'(in_ch.ref_y_change) - 20'(dby);
      zero_r <= (in_ch.mag_x == '0) && (in_ch.mag_y == '0) && (in_ch.mag_z == '0);
      nx_r   <= '0;
      nz_r   <= '0;
    end

    if (state_r == pmc_pkg::ST_MUL) begin
      prod_r <= mul_p;
      case (step_r)
        5'd1: acc_r <= prod_r[56:0];
        5'd2: acc_r <= acc_r + prod_r[56:0];
        5'd3: begin
          az_r     <= prod_r[47:0];
          tq_abs_r <= {1'b0, (acc_r[56] ? 57'(-acc_r) : 57'(acc_r))};
          tq_neg_r <= !acc_r[56] && (acc_r != '0);
        end
        5'd4: ax_r <= prod_r[47:0];
        5'd5: b2_r <= prod_r[35:0];
        5'd6, 5'd7: b2_r <= b2_r + prod_r[35:0];
        5'd8: my_r <= my_sat;
        5'd9, 5'd10, 5'd11, 5'd12: nx_r <= nx_r + part_sh;
        5'd13, 5'd14, 5'd15, 5'd16: nz_r <= nz_r + part_sh;
        default: ;
      endcase
    end

    if (state_r == pmc_pkg::ST_DIV_START) begin
      if (div_sat) begin
        if (div_z_r) mz_r <= div_res;
        else         mx_r <= div_res;
      end else begin
        rem_r <= n_sel[65:14];
        low_r <= n_sel[13:0];
        q_r   <= '0;
      end
    end

    if (state_r == pmc_pkg::ST_DIV_ITER) begin
      rem_r <= div_ge ? 52'(trial - {1'b0, den}) : trial[51:0];
      low_r <= {low_r[12:0], 1'b0};
      q_r   <= q_fin[12:0];
      if (cnt_r == pmc_pkg::DIV_LAST) begin
        if (div_z_r) mz_r <= div_res;
        else         mx_r <= div_res;
      end
    end

    if (out_load) begin
      out_mx_r   <= zero_r ? '0 : mx_r;
      out_my_r   <= my_r;
      out_mz_r   <= zero_r ? '0 : mz_r;
      out_zero_r <= zero_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.moment_x   = out_mx_r;
  assign out_ch.moment_y   = out_my_r;
  assign out_ch.moment_z   = out_mz_r;
  assign out_ch.field_zero = out_zero_r;

endmodule

// ===== rtl/core/pmc_checker.sv =====
// Port-level assertions for the pitch PD magnetorquer controller, bound to the top level.
module pmc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [pmc_pkg::MOMENT_W-1:0]   moment_x,
  input logic signed [pmc_pkg::MOMENT_W-1:0]   moment_y,
  input logic signed [pmc_pkg::MOMENT_W-1:0]   moment_z,
  input logic                                  field_zero
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(moment_x) && $stable(moment_y)
                                && $stable(moment_z) && $stable(field_zero))
    else $error("result changed while stalled");

  // An accepted item keeps the input closed while it is being worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // A zero field clears both cross-axis moments.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && field_zero |-> moment_x == '0 && moment_z == '0)
    else $error("nonzero X or Z moment with zero field");

  // Every moment stays within the saturation limit.
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> moment_x <= pmc_pkg::SAT_LIMIT && moment_x >= -pmc_pkg::SAT_LIMIT
               && moment_y <= pmc_pkg::SAT_LIMIT && moment_y >= -pmc_pkg::SAT_LIMIT
               && moment_z <= pmc_pkg::SAT_LIMIT && moment_z >= -pmc_pkg::SAT_LIMIT)
    else $error("moment beyond saturation limit");

endmodule

bind pitch_pd_magnetorquer_control pmc_checker u_pmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .moment_x   (out_ch.moment_x),
  .moment_y   (out_ch.moment_y),
  .moment_z   (out_ch.moment_z),
  .field_zero (out_ch.field_zero)
);

// ===== tb/sv/pitch_pd_magnetorquer_control_test.sv =====
// Self-checking testbench for the pitch PD magnetorquer controller.
module pitch_pd_magnetorquer_control_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MOMENT_LIMIT = 13107;
  localparam longint unsigned NT_PER_TESLA = 64'd1000000000;
  localparam logic [pmc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 300;
  localparam int PHASE_COUNT = 6;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [pmc_pkg::MAG_W-1:0]   mag_x;
    logic signed [pmc_pkg::MAG_W-1:0]   mag_y;
    logic signed [pmc_pkg::MAG_W-1:0]   mag_z;
    logic signed [pmc_pkg::ANGLE_W-1:0] pitch_angle;
    logic signed [pmc_pkg::RATE_W-1:0]  pitch_rate;
    logic signed [pmc_pkg::MAG_W-1:0]   ref_y_change;
  } field_sample_t;

  typedef struct {
    logic [pmc_pkg::MOMENT_W-1:0] moment_x;
    logic [pmc_pkg::MOMENT_W-1:0] moment_y;
    logic [pmc_pkg::MOMENT_W-1:0] moment_z;
    logic                         field_zero;
  } moment_set_t;

  class moment_scoreboard;
    longint p_gain = 0;
    longint d_gain = 0;
    longint nut_gain = 0;
    logic signed [pmc_pkg::MAG_W-1:0] last_mag_y = '0;
    bit have_last = 0;
    moment_set_t awaited_moments[$];
    int errors = 0;
    int checked = 0;
    int zero_fields = 0;
    int saturated = 0;

    function void set_gain(logic [pmc_pkg::CFG_IDX_W-1:0] idx, logic [pmc_pkg::CFG_W-1:0] value);
      case (idx)
        pmc_pkg::REG_PITCH_P_GAIN: p_gain = longint'($signed(value));
        pmc_pkg::REG_PITCH_D_GAIN: d_gain = longint'($signed(value));
        pmc_pkg::REG_NUTATION_GAIN: nut_gain = longint'($signed(value));
        default: ;
      endcase
    endfunction

    function logic [pmc_pkg::MOMENT_W-1:0] cross_term(longint b, longint tq,
                                                      longint unsigned den);
      logic [127:0] num;
      logic [127:0] quo;
      longint unsigned ab;
      longint unsigned at;
      longint mag;
      ab = (b < 0) ? -b : b;
      at = (tq < 0) ? -tq : tq;
      num = ab;
      num = num * NT_PER_TESLA;
      num = num * at;
      quo = num / den;
      mag = (quo > MOMENT_LIMIT) ? MOMENT_LIMIT : longint'(quo[15:0]);
      if ((b < 0) != (tq < 0)) mag = -mag;
      return pmc_pkg::MOMENT_W'(mag);
    endfunction

    function moment_set_t predict_moments(field_sample_t s);
      longint bx, by, bz, tq, dby, my;
      longint unsigned b2;
      moment_set_t m;
      bx = longint'(s.mag_x);
      by = longint'(s.mag_y);
      bz = longint'(s.mag_z);
      tq = -(p_gain * longint'(s.pitch_angle) + d_gain * longint'(s.pitch_rate));
      dby = have_last ? by - longint'(last_mag_y) : 0;
      b2 = bx * bx + by * by + bz * bz;
      m.field_zero = (b2 == 0);
      if (b2 == 0) begin
        m.moment_x = '0;
        m.moment_z = '0;
      end else begin
        m.moment_x = cross_term(-bz, tq, b2 << 16);
        m.moment_z = cross_term(bx, tq, b2 << 16);
      end
      my = -nut_gain * (dby - longint'(s.ref_y_change));
      if (my > MOMENT_LIMIT) my = MOMENT_LIMIT;
      else if (my < -MOMENT_LIMIT) my = -MOMENT_LIMIT;
      m.moment_y = pmc_pkg::MOMENT_W'(my);
      last_mag_y = s.mag_y;
      have_last = 1;
      return m;
    endfunction

    function void note_sample(field_sample_t s);
      awaited_moments.push_back(predict_moments(s));
    endfunction

    function int pending();
      return awaited_moments.size();
    endfunction

    task report(string what, int got, int want);
      if (errors < 50) begin
        $display("%0t: %s mismatch on result %0d: got %0d, want %0d",
                 $realtime, what, checked, got, want);
      end
      errors++;
    endtask

    task check_moment(moment_set_t got);
      moment_set_t want;
      if (awaited_moments.size() == 0) begin
        report("unexpected result", int'($signed(got.moment_x)), 0);
        return;
      end
      want = awaited_moments.pop_front();
      checked++;
      if (want.field_zero) zero_fields++;
      if ($signed(want.moment_x) == MOMENT_LIMIT || $signed(want.moment_x) == -MOMENT_LIMIT ||
          $signed(want.moment_y) == MOMENT_LIMIT || $signed(want.moment_y) == -MOMENT_LIMIT ||
          $signed(want.moment_z) == MOMENT_LIMIT || $signed(want.moment_z) == -MOMENT_LIMIT) begin
        saturated++;
      end
      if (got.moment_x !== want.moment_x)
        report("moment_x", int'($signed(got.moment_x)), int'($signed(want.moment_x)));
      if (got.moment_y !== want.moment_y)
        report("moment_y", int'($signed(got.moment_y)), int'($signed(want.moment_y)));
      if (got.moment_z !== want.moment_z)
        report("moment_z", int'($signed(got.moment_z)), int'($signed(want.moment_z)));
      if (got.field_zero !== want.field_zero)
        report("field_zero", int'(got.field_zero), int'(want.field_zero));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pmc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pmc_pkg::CFG_W-1:0] cfg_wdata;

  pmc_in_if in_ch ();
  pmc_out_if out_ch ();

  moment_scoreboard sb = new;
  int send_idle_pct = 37;
  int recv_idle_pct = 69;
  int cycle_count = 0;
  logic signed [pmc_pkg::MAG_W-1:0] stim_last_y = '0;

  pitch_pd_magnetorquer_control i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    moment_set_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.moment_x = out_ch.moment_x;
      got.moment_y = out_ch.moment_y;
      got.moment_z = out_ch.moment_z;
      got.field_zero = out_ch.field_zero;
      sb.check_moment(got);
    end
  end

  function automatic int span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic field_sample_t random_sample();
    field_sample_t s;
    int kind, lim, by;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      s.mag_x = pmc_pkg::MAG_W'($urandom);
      s.mag_y = pmc_pkg::MAG_W'($urandom);
      s.mag_z = pmc_pkg::MAG_W'($urandom);
      s.pitch_angle = pmc_pkg::ANGLE_W'($urandom);
      s.pitch_rate = pmc_pkg::RATE_W'($urandom);
      s.ref_y_change = pmc_pkg::MAG_W'($urandom);
    end else begin
      lim = (kind < 25) ? 300 : 60000;
      by = span(lim);
      s.mag_x = pmc_pkg::MAG_W'(span(lim));
      s.mag_y = pmc_pkg::MAG_W'(by);
      s.mag_z = pmc_pkg::MAG_W'(span(lim));
      if ($urandom_range(0, 99) < 4) begin
        s.mag_x = '0;
        s.mag_y = '0;
        s.mag_z = '0;
        by = 0;
      end
      s.pitch_angle = pmc_pkg::ANGLE_W'((kind % 10 == 0) ? span(11796480) : span(20000));
      s.pitch_rate = pmc_pkg::RATE_W'((kind % 10 == 1) ? span(2097151) : span(20000));
      if (kind % 10 == 2) s.ref_y_change = pmc_pkg::MAG_W'($urandom);
      else s.ref_y_change = pmc_pkg::MAG_W'(by - int'(stim_last_y) + span(50));
    end
    return s;
  endfunction

  task automatic send_sample(input field_sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mag_x <= s.mag_x;
    in_ch.mag_y <= s.mag_y;
    in_ch.mag_z <= s.mag_z;
    in_ch.pitch_angle <= s.pitch_angle;
    in_ch.pitch_rate <= s.pitch_rate;
    in_ch.ref_y_change <= s.ref_y_change;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s);
    stim_last_y = s.mag_y;
    @(negedge clk);
  endtask

  task automatic send_fields(input int bx, by, bz, angle, rate, ref_dy);
    field_sample_t s;
    s.mag_x = pmc_pkg::MAG_W'(bx);
    s.mag_y = pmc_pkg::MAG_W'(by);
    s.mag_z = pmc_pkg::MAG_W'(bz);
    s.pitch_angle = pmc_pkg::ANGLE_W'(angle);
    s.pitch_rate = pmc_pkg::RATE_W'(rate);
    s.ref_y_change = pmc_pkg::MAG_W'(ref_dy);
    send_sample(s);
  endtask

  task automatic write_reg(input logic [pmc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmc_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.set_gain(idx, value);
    @(negedge clk);
  endtask

  task automatic write_gains(input logic [pmc_pkg::CFG_W-1:0] p, d, n);
    write_reg(pmc_pkg::REG_PITCH_P_GAIN, p);
    write_reg(pmc_pkg::REG_PITCH_D_GAIN, d);
    write_reg(pmc_pkg::REG_NUTATION_GAIN, n);
    write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mag_x = '0;
    in_ch.mag_y = '0;
    in_ch.mag_z = '0;
    in_ch.pitch_angle = '0;
    in_ch.pitch_rate = '0;
    in_ch.ref_y_change = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The first item after reset sees no field change on the Y axis.
    write_gains(32'd2, -32'sd1, 32'd100);
    send_fields(20000, -15000, 30000, 6000, -3000, 40);
    send_fields(20040, -14990, 29950, 6100, -2900, 10);
    send_fields(0, 0, 0, 5000, 100, 7);
    send_fields(0, 0, 0, 5000, 100, -7);
    send_fields(131071, 131071, 131071, 11796480, 2097151, 131071);
    send_fields(-131072, -131072, -131072, -11796480, -2097152, -131072);
    send_fields(1, 0, 0, 8000, 0, 0);
    send_fields(0, 0, -1, -8000, 0, 0);
    send_fields(0, 5, 0, 8000, 0, 5);
    send_fields(25000, 3000, -40000, 0, 0, 0);
    send_fields(30000, 0, 0, 16777215, 0, 0);
    send_fields(0, 0, 30000, -16777216, 0, 0);
    send_fields(-131072, 0, 0, 100, 200, 0);
    send_fields(0, 0, -131072, 100, 200, 0);
    send_fields(45000, -20000, 12000, -12000, 5000, -300);
    send_fields(-52000, 8000, -31000, 3000, -15000, 131071);
    send_fields(60000, 60000, 60000, 20000, 20000, -131072);
    in_ch.valid <= 1'b0;

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain();
      case (phase / 2)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        1: write_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        2: write_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        3: write_gains($urandom, $urandom, $urandom);
        5: write_gains('0, span(3), span(200));
        default: write_gains(span(3), span(3), span(200));
      endcase
      repeat (PHASE_ITEMS) send_sample(random_sample());
      in_ch.valid <= 1'b0;
    end

    while (sb.pending() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Checked %0d moment results over six gain settings and three flow-control mixes,",
             sb.checked);
    $display("including %0d zero-field results and %0d with a saturated moment.",
             sb.zero_fields, sb.saturated);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pmc_pkg.sv
rtl/core/pmc_if.sv
rtl/core/pitch_pd_magnetorquer_control.sv
rtl/core/pmc_checker.sv
tb/sv/pitch_pd_magnetorquer_control_test.sv
